@@ rtl/isots_pkg.sv @@
// Shared types, constants and calendar tables for the timestamp converter.
`timescale 1ns / 1ps

package isots_pkg;

    localparam int unsigned YEAR_W = 8;
    localparam int unsigned DAYS_W = 17;
    localparam int unsigned EPOCH_W = 33;

    localparam logic [11:0] YEAR_MIN = 12'd2000;
    localparam logic [11:0] YEAR_MAX = 12'd2200;
    localparam logic [6:0] ZONE_HOURS_MAX = 7'd14;
    localparam logic [6:0] MINUTE_MAX = 7'd59;

    localparam logic [33:0] SEC_PER_DAY = 34'd86400;
    localparam logic [16:0] SEC_PER_HOUR = 17'd3600;
    localparam logic [16:0] SEC_PER_MIN = 17'd60;

    // days from 1600-03-01 to 1970-01-01
    localparam logic [19:0] DAYS_1600_TO_EPOCH = 20'd135080;
    localparam logic [9:0] YEAR_BIAS_1600 = 10'd400;

    localparam logic [EPOCH_W-1:0] EPOCH_MIN_OK = 33'd946634400;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX_OK = 33'd7289704799;

    typedef struct packed {
        logic                 ok;
        logic [YEAR_W-1:0]    year;
        logic [3:0]           month;
        logic [4:0]           day;
        logic [4:0]           hour;
        logic [5:0]           minute;
        logic [5:0]           second;
        logic [6:0]           zone_hours;
        logic [6:0]           zone_minutes;
        logic                 zone_negative;
    } t_record;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    // length of a month; year is counted from 2000 and stays within 0..200
    function automatic logic [4:0] month_days(input logic [YEAR_W-1:0] year,
                                              input logic [3:0] month);
        logic leap;
        logic [4:0] len;
        leap = (year[1:0] == 2'd0) && (year != 8'd100) && (year != 8'd200);
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                        len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

    // day of a year that starts on March 1
    function automatic logic [8:0] march_doy(input logic [3:0] month);
        logic [8:0] doy;
        case (month)
            4'd3:    doy = 9'd0;
            4'd4:    doy = 9'd31;
            4'd5:    doy = 9'd61;
            4'd6:    doy = 9'd92;
            4'd7:    doy = 9'd122;
            4'd8:    doy = 9'd153;
            4'd9:    doy = 9'd184;
            4'd10:   doy = 9'd214;
            4'd11:   doy = 9'd245;
            4'd12:   doy = 9'd275;
            4'd1:    doy = 9'd306;
            4'd2:    doy = 9'd337;
            default: doy = 9'd0;
        endcase
        return doy;
    endfunction

endpackage

@@ rtl/isots_if.sv @@
// Stream interfaces for character beats and epoch result beats.
`timescale 1ns / 1ps

interface isots_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source(output valid, output char_code, output last_char, input ready);
    modport sink(input valid, input char_code, input last_char, output ready);
endinterface

interface isots_epoch_if;
    logic        valid;
    logic        ready;
    logic        timestamp_ok;
    logic [32:0] epoch_seconds;

    modport source(output valid, output timestamp_ok, output epoch_seconds, input ready);
    modport sink(input valid, input timestamp_ok, input epoch_seconds, output ready);
endinterface

@@ rtl/iso8601_timestamp_to_epoch.sv @@
// ISO 8601 timestamp to Unix epoch converter, top level.
// Throughput: one character beat per cycle; ready drops only while the record queue is full.
// The result beat leaves the output register after the record passes the queue and the converter.
// The converter sequencer steps pop, days, scale, sum per string and pops the next record only after sum.
// Reset: synchronous, active low; clears the parser, the queue pointers, the converter state and the output valid.
`timescale 1ns / 1ps

module iso8601_timestamp_to_epoch #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    isots_char_if.sink     i_char,
    isots_epoch_if.source  o_epoch
);

    isots_pkg::t_record       push_rec;
    isots_pkg::t_record       pop_rec;
    isots_pkg::t_queue_status q_status;
    logic                     push;
    logic                     pop;

    isots_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (i_char),
        .i_q_full (q_status.full),
        .o_push   (push),
        .o_rec    (push_rec)
    );

    isots_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_rec (push_rec),
        .i_pop      (pop),
        .o_pop_rec  (pop_rec),
        .o_status   (q_status)
    );

    isots_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rec      (pop_rec),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_epoch    (o_epoch)
    );

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty record queue");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("push into full record queue");

    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_epoch.valid && !o_epoch.timestamp_ok) |-> (o_epoch.epoch_seconds == '0))
        else $error("invalid timestamp with nonzero epoch");

    a_ok_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_epoch.valid && o_epoch.timestamp_ok) |->
        (o_epoch.epoch_seconds >= isots_pkg::EPOCH_MIN_OK &&
         o_epoch.epoch_seconds <= isots_pkg::EPOCH_MAX_OK))
        else $error("epoch outside the supported year range");

endmodule

@@ rtl/isots_front.sv @@
// Character parser: checks fields per beat and emits one record per string.
`timescale 1ns / 1ps

module isots_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    isots_char_if.sink           i_char,
    input  logic                 i_q_full,
    output logic                 o_push,
    output isots_pkg::t_record   o_rec
);

    typedef enum logic [5:0] {
        PH_FIXED      = 6'b000001,
        PH_AFTER_SEC  = 6'b000010,
        PH_FRAC_FIRST = 6'b000100,
        PH_FRAC_MORE  = 6'b001000,
        PH_ZONE       = 6'b010000,
        PH_TAIL       = 6'b100000
    } t_phase;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_Z     = 8'h5a;

    localparam logic [4:0] POS_YEAR_END   = 5'd3;
    localparam logic [4:0] POS_DASH_A     = 5'd4;
    localparam logic [4:0] POS_MONTH_END  = 5'd6;
    localparam logic [4:0] POS_DASH_B     = 5'd7;
    localparam logic [4:0] POS_DAY_END    = 5'd9;
    localparam logic [4:0] POS_DATE_SEP   = 5'd10;
    localparam logic [4:0] POS_HOUR_END   = 5'd12;
    localparam logic [4:0] POS_COLON_A    = 5'd13;
    localparam logic [4:0] POS_MINUTE_END = 5'd15;
    localparam logic [4:0] POS_COLON_B    = 5'd16;
    localparam logic [4:0] POS_SECOND_END = 5'd18;
    localparam logic [4:0] POS_ZONE_SEP   = 5'd2;
    localparam logic [4:0] POS_ZONE_END   = 5'd4;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_pos, n_pos;
    logic [11:0] r_acc, n_acc;
    logic [7:0]  r_year, n_year;
    logic [3:0]  r_month, n_month;
    logic [4:0]  r_day, n_day;
    logic [4:0]  r_hour, n_hour;
    logic [5:0]  r_minute, n_minute;
    logic [5:0]  r_second, n_second;
    logic [6:0]  r_zh, n_zh;
    logic [6:0]  r_zm, n_zm;
    logic        r_zneg, n_zneg;
    logic        r_bad, n_bad;

    logic [7:0]  c;
    logic        dig;
    logic [3:0]  d;
    logic [15:0] acc_mul;
    logic [11:0] acc_sat;
    logic [11:0] v;
    logic [11:0] year_off;
    logic [10:0] zh_mul;
    logic [10:0] zm_mul;
    logic        accept;
    t_phase      zs_phase;
    logic        zs_bad;
    logic        zs_neg;
    logic        zs_start;
    logic        zone_ok;

    assign c = i_char.char_code;
    assign dig = (c >= CH_ZERO) && (c <= CH_NINE);
    assign d = dig ? 4'(c - CH_ZERO) : 4'd0;
    assign acc_mul = {4'd0, r_acc} * 16'd10 + {12'd0, d};
    assign acc_sat = (acc_mul > 16'd4095) ? 12'd4095 : acc_mul[11:0];
    assign v = dig ? acc_sat : r_acc;
    assign year_off = v - isots_pkg::YEAR_MIN;
    assign zh_mul = {4'd0, r_zh} * 11'd10 + {7'd0, d};
    assign zm_mul = {4'd0, r_zm} * 11'd10 + {7'd0, d};

    always_comb begin
        zs_neg = r_zneg;
        zs_bad = 1'b0;
        zs_start = 1'b0;
        if (c == CH_Z) begin
            zs_phase = PH_TAIL;
        end else if (c == CH_PLUS || c == CH_DASH) begin
            zs_phase = PH_ZONE;
            zs_neg = (c == CH_DASH);
            zs_start = 1'b1;
        end else begin
            zs_phase = PH_TAIL;
            zs_bad = 1'b1;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_acc    = r_acc;
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        n_zh     = r_zh;
        n_zm     = r_zm;
        n_zneg   = r_zneg;
        n_bad    = r_bad;
        unique case (r_phase)
            PH_FIXED: begin
                if (r_pos == POS_DASH_A || r_pos == POS_DASH_B) begin
                    if (c != CH_DASH) n_bad = 1'b1;
                    n_acc = 12'd0;
                    n_pos = r_pos + 5'd1;
                end else if (r_pos == POS_DATE_SEP) begin
                    if (c != CH_T && c != CH_SPACE) n_bad = 1'b1;
                    n_acc = 12'd0;
                    n_pos = r_pos + 5'd1;
                end else if (r_pos == POS_COLON_A || r_pos == POS_COLON_B) begin
                    if (c != CH_COLON) n_bad = 1'b1;
                    n_acc = 12'd0;
                    n_pos = r_pos + 5'd1;
                end else begin
                    if (!dig) n_bad = 1'b1;
                    n_acc = v;
                    n_pos = r_pos + 5'd1;
                    if (r_pos == POS_YEAR_END) begin
                        if (v < isots_pkg::YEAR_MIN || v > isots_pkg::YEAR_MAX) begin
                            n_bad = 1'b1;
                        end else begin
                            n_year = year_off[7:0];
                        end
                        n_acc = 12'd0;
                    end else if (r_pos == POS_MONTH_END) begin
                        if (v < 12'd1 || v > 12'd12) n_bad = 1'b1;
                        n_month = v[3:0];
                        n_acc = 12'd0;
                    end else if (r_pos == POS_DAY_END) begin
                        if (v < 12'd1 ||
                            v > {7'd0, isots_pkg::month_days(r_year, r_month)}) begin
                            n_bad = 1'b1;
                        end
                        n_day = v[4:0];
                        n_acc = 12'd0;
                    end else if (r_pos == POS_HOUR_END) begin
                        if (v > 12'd23) n_bad = 1'b1;
                        n_hour = v[4:0];
                        n_acc = 12'd0;
                    end else if (r_pos == POS_MINUTE_END) begin
                        if (v > 12'd59) n_bad = 1'b1;
                        n_minute = v[5:0];
                        n_acc = 12'd0;
                    end else if (r_pos == POS_SECOND_END) begin
                        if (v > 12'd59) n_bad = 1'b1;
                        n_second = v[5:0];
                        n_acc = 12'd0;
                        n_phase = PH_AFTER_SEC;
                        n_pos = 5'd0;
                    end
                end
            end
            PH_AFTER_SEC: begin
                if (c == CH_DOT) begin
                    n_phase = PH_FRAC_FIRST;
                end else begin
                    n_phase = zs_phase;
                    n_zneg = zs_neg;
                    if (zs_bad) n_bad = 1'b1;
                    if (zs_start) n_pos = 5'd0;
                end
            end
            PH_FRAC_FIRST: begin
                if (dig) begin
                    n_phase = PH_FRAC_MORE;
                end else begin
                    n_bad = 1'b1;
                    n_phase = PH_TAIL;
                end
            end
            PH_FRAC_MORE: begin
                if (!dig) begin
                    n_phase = zs_phase;
                    n_zneg = zs_neg;
                    if (zs_bad) n_bad = 1'b1;
                    if (zs_start) n_pos = 5'd0;
                end
            end
            PH_ZONE: begin
                if (r_pos == POS_ZONE_SEP) begin
                    if (c != CH_COLON) n_bad = 1'b1;
                end else if (!dig) begin
                    n_bad = 1'b1;
                end else if (r_pos < POS_ZONE_SEP) begin
                    n_zh = zh_mul[6:0];
                end else begin
                    n_zm = zm_mul[6:0];
                end
                if (r_pos >= POS_ZONE_END) begin
                    n_phase = PH_TAIL;
                    n_pos = 5'd0;
                end else begin
                    n_pos = r_pos + 5'd1;
                end
            end
            PH_TAIL: begin
                n_bad = 1'b1;
            end
            default: begin
                n_bad = 1'b1;
                n_phase = PH_TAIL;
            end
        endcase
    end

    assign zone_ok = (n_zh <= isots_pkg::ZONE_HOURS_MAX) && (n_zm <= isots_pkg::MINUTE_MAX) &&
                     !((n_zh == isots_pkg::ZONE_HOURS_MAX) && (n_zm != 7'd0));

    assign i_char.ready = !i_q_full;
    assign accept = i_char.valid && !i_q_full;
    assign o_push = accept && i_char.last_char;

    always_comb begin
        o_rec.ok            = !n_bad && (n_phase == PH_TAIL) && zone_ok;
        o_rec.year          = n_year;
        o_rec.month         = n_month;
        o_rec.day           = n_day;
        o_rec.hour          = n_hour;
        o_rec.minute        = n_minute;
        o_rec.second        = n_second;
        o_rec.zone_hours    = n_zh;
        o_rec.zone_minutes  = n_zm;
        o_rec.zone_negative = n_zneg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_phase  <= PH_FIXED;
            r_pos    <= 5'd0;
            r_acc    <= 12'd0;
            r_year   <= 8'd0;
            r_month  <= 4'd0;
            r_day    <= 5'd0;
            r_hour   <= 5'd0;
            r_minute <= 6'd0;
            r_second <= 6'd0;
            r_zh     <= 7'd0;
            r_zm     <= 7'd0;
            r_zneg   <= 1'b0;
            r_bad    <= 1'b0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_acc    <= n_acc;
            r_year   <= n_year;
            r_month  <= n_month;
            r_day    <= n_day;
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= n_second;
            r_zh     <= n_zh;
            r_zm     <= n_zm;
            r_zneg   <= n_zneg;
            r_bad    <= n_bad;
        end
    end

endmodule

@@ rtl/isots_queue.sv @@
// Small record queue between the parser and the converter.
`timescale 1ns / 1ps

module isots_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  isots_pkg::t_record         i_push_rec,
    input  logic                       i_pop,
    output isots_pkg::t_record         o_pop_rec,
    output isots_pkg::t_queue_status   o_status
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    isots_pkg::t_record r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_status.full  = (r_count == CNT_FULL);
    assign o_status.empty = (r_count == '0);
    assign o_pop_rec = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/isots_back.sv @@
// Converter: turns a parsed record into epoch seconds over a short sequence.
`timescale 1ns / 1ps

module isots_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  isots_pkg::t_record         i_rec,
    input  isots_pkg::t_queue_status   i_q_status,
    output logic                       o_pop,
    isots_epoch_if.source              o_epoch
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DAYS  = 4'b0010,
        S_SCALE = 4'b0100,
        S_SUM   = 4'b1000
    } t_state;

    t_state                          r_state, n_state;
    isots_pkg::t_record              r_rec;
    logic [isots_pkg::DAYS_W-1:0]    r_days;
    logic [33:0]                     r_day_sec;
    logic [16:0]                     r_tod;
    logic [18:0]                     r_off;
    logic                            r_out_valid;
    logic                            r_out_ok;
    logic [isots_pkg::EPOCH_W-1:0]   r_out_epoch;

    logic        early;
    logic [9:0]  t;
    logic [2:0]  q100;
    logic        q400;
    logic [19:0] days_sum;
    logic [33:0] total;
    logic        out_free;
    logic        load_out;

    assign early = (r_rec.month <= 4'd2);
    assign t = {2'd0, r_rec.year} + isots_pkg::YEAR_BIAS_1600 - {9'd0, early};
    assign q400 = (t >= 10'd400);
    assign q100 = (t >= 10'd600) ? 3'd6 : (t >= 10'd500) ? 3'd5 : q400 ? 3'd4 : 3'd3;
    assign days_sum = {10'd0, t} * 20'd365 + {12'd0, t[9:2]} + {19'd0, q400}
                    + {11'd0, isots_pkg::march_doy(r_rec.month)} + {15'd0, r_rec.day}
                    - {17'd0, q100} - 20'd1 - isots_pkg::DAYS_1600_TO_EPOCH;

    assign total = r_rec.zone_negative ?
                   r_day_sec + {17'd0, r_tod} + {15'd0, r_off} :
                   r_day_sec + {17'd0, r_tod} - {15'd0, r_off};

    assign out_free = !r_out_valid || o_epoch.ready;
    assign load_out = (r_state == S_SUM) && out_free;
    assign o_pop = (r_state == S_IDLE) && !i_q_status.empty;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (!i_q_status.empty) n_state = S_DAYS;
            S_DAYS:  n_state = S_SCALE;
            S_SCALE: n_state = S_SUM;
            S_SUM:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_rec;
        end
        if (r_state == S_DAYS) begin
            r_days <= days_sum[isots_pkg::DAYS_W-1:0];
        end
        if (r_state == S_SCALE) begin
            r_day_sec <= {17'd0, r_days} * isots_pkg::SEC_PER_DAY;
            r_tod <= {12'd0, r_rec.hour} * isots_pkg::SEC_PER_HOUR
                   + {11'd0, r_rec.minute} * isots_pkg::SEC_PER_MIN
                   + {11'd0, r_rec.second};
            r_off <= {12'd0, r_rec.zone_hours} * {2'd0, isots_pkg::SEC_PER_HOUR}
                   + {12'd0, r_rec.zone_minutes} * {2'd0, isots_pkg::SEC_PER_MIN};
        end
        if (load_out) begin
            r_out_ok <= r_rec.ok;
            r_out_epoch <= r_rec.ok ? total[isots_pkg::EPOCH_W-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_epoch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_epoch.valid = r_out_valid;
    assign o_epoch.timestamp_ok = r_out_ok;
    assign o_epoch.epoch_seconds = r_out_epoch;

endmodule
